// ----- src/sie_pkg.sv -----
// ----------------------------------------------------------------------------
// sie_pkg
// Shared types and constants for the sheath incident energy pipeline.
// ----------------------------------------------------------------------------
package sie_pkg;

	localparam int FRAC_W  = 24;   // fraction bits of the log2 result
	localparam int EXP_W   = 5;    // integer part of log2 of a 24-bit value
	localparam int MANT_W  = 32;   // normalized mantissa width
	localparam int LOG_W   = EXP_W + FRAC_W;
	localparam int FIRST_SQ_STAGE = 3;
	localparam int LAST_SQ_STAGE  = FIRST_SQ_STAGE + FRAC_W - 1;
	localparam int NUM_STAGES     = LAST_SQ_STAGE + 4;

	// log2(qe / (2 pi me)) - 8, in Q.24
	localparam logic [LOG_W-1:0] LOG_OFFSET = 29'd448190624;
	// ln2 / 2 in Q0.32
	localparam logic [31:0] HALF_LN2 = 32'd1488522236;
	// 2.8 in Q8.16
	localparam logic [23:0] FACTOR_FALLBACK = 24'd183501;

	typedef struct packed {
		logic               opcode;
		logic signed [23:0] ion_temp;
		logic signed [23:0] electron_temp;
		logic               fallback;
	} item_t;

	typedef struct packed {
		logic [EXP_W-1:0]  expo;
		logic [MANT_W-1:0] mant;
		logic [FRAC_W-1:0] frac;
	} lane_t;

endpackage

// ----- src/sie_prep.sv -----
// ----------------------------------------------------------------------------
// sie_prep
// First stage: registers the transaction, takes the speed magnitude and
// picks the log arguments and the fallback condition.
// ----------------------------------------------------------------------------
module sie_prep (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic               opcode,
	input  logic signed [23:0] ion_temp,
	input  logic signed [23:0] electron_temp,
	input  logic signed [23:0] flow_speed,
	output logic               valid_s1,
	output sie_pkg::item_t     item_s1,
	output logic [23:0]        x_te_s1,
	output logic [23:0]        x_u_s1
);
	import sie_pkg::*;

	logic        te_pos;
	logic        u_nz;
	logic [23:0] mag;

	assign te_pos = !electron_temp[23] && (electron_temp != 24'sd0);
	assign u_nz   = (flow_speed != 24'sd0);
	assign mag    = flow_speed[23] ? 24'(-flow_speed) : flow_speed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// Unused lanes get an argument of one so that they idle harmlessly.
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1.opcode        <= opcode;
			item_s1.ion_temp      <= ion_temp;
			item_s1.electron_temp <= electron_temp;
			item_s1.fallback      <= !te_pos || !u_nz;
			x_te_s1               <= te_pos ? electron_temp : 24'd1;
			x_u_s1                <= u_nz ? mag : 24'd1;
		end
	end

endmodule

// ----- src/sie_norm.sv -----
// ----------------------------------------------------------------------------
// sie_norm
// Second stage: finds the top set bit of both log arguments and shifts
// each into a mantissa with its leading one at bit 31.
// ----------------------------------------------------------------------------
module sie_norm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  sie_pkg::item_t in_item,
	input  logic [23:0]    x_te,
	input  logic [23:0]    x_u,
	output logic           valid_s2,
	output sie_pkg::item_t item_s2,
	output sie_pkg::lane_t te_lane_s2,
	output sie_pkg::lane_t u_lane_s2
);
	import sie_pkg::*;

	function automatic lane_t norm_lane(input logic [23:0] x);
		lane_t            r;
		logic [EXP_W-1:0] n;
		n = '0;
		for (int i = 0; i < 24; i++) begin
			if (x[i]) begin
				n = EXP_W'(i);
			end
		end
		r.expo = n;
		r.mant = {8'b0, x} << (EXP_W'(MANT_W - 1) - n);
		r.frac = '0;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2    <= in_item;
			te_lane_s2 <= norm_lane(x_te);
			u_lane_s2  <= norm_lane(x_u);
		end
	end

endmodule

// ----- src/sie_sq_stage.sv -----
// ----------------------------------------------------------------------------
// sie_sq_stage
// One step of the log2 chain: squares both mantissas and yields one more
// fraction bit for each lane.
// ----------------------------------------------------------------------------
module sie_sq_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  sie_pkg::item_t in_item,
	input  sie_pkg::lane_t in_te,
	input  sie_pkg::lane_t in_u,
	output logic           valid_sk,
	output sie_pkg::item_t item_sk,
	output sie_pkg::lane_t te_lane_sk,
	output sie_pkg::lane_t u_lane_sk
);
	import sie_pkg::*;

	// The mantissa stays in [2^31, 2^32); a square at or above 2 gives a one.
	function automatic lane_t square_step(input lane_t l);
		lane_t                 r;
		logic [2*MANT_W-1:0]   sq;
		logic [MANT_W:0]       t;
		sq = {{MANT_W{1'b0}}, l.mant} * {{MANT_W{1'b0}}, l.mant};
		t  = sq[2*MANT_W-1:MANT_W-1];
		r.expo = l.expo;
		r.mant = t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
		r.frac = {l.frac[FRAC_W-2:0], t[MANT_W]};
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sk <= 1'b0;
		end else if (en) begin
			valid_sk <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_sk    <= in_item;
			te_lane_sk <= square_step(in_te);
			u_lane_sk  <= square_step(in_u);
		end
	end

endmodule

// ----- src/sie_factor.sv -----
// ----------------------------------------------------------------------------
// sie_factor
// Combines the two logarithms into the log-domain sheath term, scales it
// by ln2/2 and selects the factor in use.
// ----------------------------------------------------------------------------
module sie_factor (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en_a,
	input  logic           en_b,
	input  logic           in_valid,
	input  sie_pkg::item_t in_item,
	input  sie_pkg::lane_t in_te,
	input  sie_pkg::lane_t in_u,
	input  logic [23:0]    fixed_factor,
	output logic           valid_a,
	output logic           valid_b,
	output sie_pkg::item_t item_b,
	output logic [23:0]    factor_b
);
	import sie_pkg::*;

	logic               valid_sa;
	item_t              item_sa;
	logic signed [31:0] s_sa;
	logic signed [31:0] s_comb;
	logic [63:0]        prod;
	logic [23:0]        computed;
	logic [23:0]        factor_sel;

	assign s_comb = $signed({3'b0, in_te.expo, in_te.frac})
		- $signed({2'b0, in_u.expo, in_u.frac, 1'b0})
		+ $signed({3'b0, LOG_OFFSET});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sa <= 1'b0;
		end else if (en_a) begin
			valid_sa <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_a) begin
			item_sa <= in_item;
			s_sa    <= s_comb;
		end
	end

	// The scaled term stays well below 2^24, so the top bits need no clamp.
	assign prod     = {33'b0, s_sa[30:0]} * {32'b0, HALF_LN2} + (64'd1 << 39);
	assign computed = (s_sa <= 32'sd0) ? 24'd0 : prod[63:40];

	always_comb begin
		if (fixed_factor != 24'd0) begin
			factor_sel = fixed_factor;
		end else if (item_sa.fallback) begin
			factor_sel = FACTOR_FALLBACK;
		end else begin
			factor_sel = computed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b <= 1'b0;
		end else if (en_b) begin
			valid_b <= valid_sa;
		end
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			item_b   <= item_sa;
			factor_b <= factor_sel;
		end
	end

	assign valid_a = valid_sa;

endmodule

// ----- src/sie_energy.sv -----
// ----------------------------------------------------------------------------
// sie_energy
// Forms the base energy and factor * Te, then adds, rounds to Q24.8,
// clamps at zero and saturates high.
// ----------------------------------------------------------------------------
module sie_energy (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en_a,
	input  logic           en_b,
	input  logic           in_valid,
	input  sie_pkg::item_t in_item,
	input  logic [23:0]    in_factor,
	output logic           valid_a,
	output logic           valid_b,
	output logic [23:0]    factor_b,
	output logic [31:0]    energy_b,
	output logic           sat_b
);
	import sie_pkg::*;

	logic               valid_sa;
	logic [23:0]        factor_sa;
	logic signed [49:0] base_sa;
	logic signed [49:0] fte_sa;
	logic signed [49:0] ti_x;
	logic signed [49:0] te_x;
	logic signed [49:0] base;
	logic signed [49:0] fte;
	logic signed [49:0] sum;
	logic [49:0]        rounded;

	assign ti_x = {{26{in_item.ion_temp[23]}}, in_item.ion_temp};
	assign te_x = {{26{in_item.electron_temp[23]}}, in_item.electron_temp};
	assign base = in_item.opcode ? (ti_x <<< 17)
		: (((ti_x <<< 1) + ti_x) <<< 16) + (te_x <<< 15);
	assign fte  = $signed({26'b0, in_factor}) * te_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sa <= 1'b0;
		end else if (en_a) begin
			valid_sa <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_a) begin
			factor_sa <= in_factor;
			base_sa   <= base;
			fte_sa    <= fte;
		end
	end

	assign sum     = base_sa + fte_sa;
	assign rounded = (50'(sum) + 50'd32768) >> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b <= 1'b0;
		end else if (en_b) begin
			valid_b <= valid_sa;
		end
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			factor_b <= factor_sa;
			if (sum <= 50'sd0) begin
				energy_b <= 32'd0;
				sat_b    <= 1'b0;
			end else if (rounded[49:32] != 18'd0) begin
				energy_b <= 32'hFFFF_FFFF;
				sat_b    <= 1'b1;
			end else begin
				energy_b <= rounded[31:0];
				sat_b    <= 1'b0;
			end
		end
	end

	assign valid_a = valid_sa;

endmodule

// ----- src/sheath_incident_energy.sv -----
// Throughput: one transaction per cycle unless stalled; the 24-stage log2
// squaring chain with two 32x32 multipliers per stage sets the depth.
// Each stage advances when it is empty or the next one advances, so bubbles
// close up while the output is stalled.
// Reset clears all valid bits and the fixed sheath factor register to zero.
// ----------------------------------------------------------------------------
// sheath_incident_energy
// Pipelined sheath factor and incident energy of one plasma cell.
// ----------------------------------------------------------------------------
module sheath_incident_energy (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [23:0]        fixed_sheath_factor,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic signed [23:0] ion_temp,
	input  logic signed [23:0] electron_temp,
	input  logic signed [23:0] flow_speed,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [23:0]        sheath_factor,
	output logic [31:0]        incident_energy,
	output logic               saturated
);
	import sie_pkg::*;

	logic [1:NUM_STAGES] valid_s;
	logic [1:NUM_STAGES] en;
	logic [23:0]         fixed_factor_q;
	logic [23:0]         x_te_s1;
	logic [23:0]         x_u_s1;
	item_t               item_s   [1:LAST_SQ_STAGE];
	lane_t               te_lane_s[2:LAST_SQ_STAGE];
	lane_t               u_lane_s [2:LAST_SQ_STAGE];
	item_t               item_s28;
	logic [23:0]         factor_s28;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_factor_q <= 24'd0;
		end else if (cfg_valid) begin
			fixed_factor_q <= fixed_sheath_factor;
		end
	end

	assign en[NUM_STAGES] = !valid_s[NUM_STAGES] || !out_stall;
	for (genvar k = 1; k < NUM_STAGES; k++) begin : g_en
		assign en[k] = !valid_s[k] || en[k+1];
	end
	assign in_stall = !en[1];

	sie_prep u_prep (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en[1]),
		.in_valid      (in_valid),
		.opcode        (opcode),
		.ion_temp      (ion_temp),
		.electron_temp (electron_temp),
		.flow_speed    (flow_speed),
		.valid_s1      (valid_s[1]),
		.item_s1       (item_s[1]),
		.x_te_s1       (x_te_s1),
		.x_u_s1        (x_u_s1)
	);

	sie_norm u_norm (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en[2]),
		.in_valid   (valid_s[1]),
		.in_item    (item_s[1]),
		.x_te       (x_te_s1),
		.x_u        (x_u_s1),
		.valid_s2   (valid_s[2]),
		.item_s2    (item_s[2]),
		.te_lane_s2 (te_lane_s[2]),
		.u_lane_s2  (u_lane_s[2])
	);

	for (genvar k = FIRST_SQ_STAGE; k <= LAST_SQ_STAGE; k++) begin : g_sq
		sie_sq_stage u_sq (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en[k]),
			.in_valid   (valid_s[k-1]),
			.in_item    (item_s[k-1]),
			.in_te      (te_lane_s[k-1]),
			.in_u       (u_lane_s[k-1]),
			.valid_sk   (valid_s[k]),
			.item_sk    (item_s[k]),
			.te_lane_sk (te_lane_s[k]),
			.u_lane_sk  (u_lane_s[k])
		);
	end

	sie_factor u_factor (
		.clk          (clk),
		.arst_n       (arst_n),
		.en_a         (en[LAST_SQ_STAGE+1]),
		.en_b         (en[LAST_SQ_STAGE+2]),
		.in_valid     (valid_s[LAST_SQ_STAGE]),
		.in_item      (item_s[LAST_SQ_STAGE]),
		.in_te        (te_lane_s[LAST_SQ_STAGE]),
		.in_u         (u_lane_s[LAST_SQ_STAGE]),
		.fixed_factor (fixed_factor_q),
		.valid_a      (valid_s[LAST_SQ_STAGE+1]),
		.valid_b      (valid_s[LAST_SQ_STAGE+2]),
		.item_b       (item_s28),
		.factor_b     (factor_s28)
	);

	sie_energy u_energy (
		.clk       (clk),
		.arst_n    (arst_n),
		.en_a      (en[LAST_SQ_STAGE+3]),
		.en_b      (en[NUM_STAGES]),
		.in_valid  (valid_s[LAST_SQ_STAGE+2]),
		.in_item   (item_s28),
		.in_factor (factor_s28),
		.valid_a   (valid_s[LAST_SQ_STAGE+3]),
		.valid_b   (valid_s[NUM_STAGES]),
		.factor_b  (sheath_factor),
		.energy_b  (incident_energy),
		.sat_b     (saturated)
	);

	assign out_valid = valid_s[NUM_STAGES];

endmodule

// ----- tb/sv/tb_sheath_incident_energy.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sheath_incident_energy
// Self-checking testbench for the sheath incident energy pipeline. A driver
// sends plasma cells from a queue, an internal predictor computes the expected
// sheath factor and incident energy of each accepted cell, and a monitor
// compares every result in order. Phases vary the fixed factor register and
// the amount of idling on both sides.
// ----------------------------------------------------------------------------
module tb_sheath_incident_energy;
	import sie_pkg::*;

	localparam logic OP_TARGET = 1'b0;  // 3Ti + 0.5Te
	localparam logic OP_RADIAL = 1'b1;  // 2Ti

	localparam logic signed [23:0] T_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] T_MIN = 24'sh800000;

	localparam int IDLE_HEAVY    = 88;
	localparam int IDLE_LIGHT    = 15;
	localparam int PHASE_CELLS   = 140;
	localparam int DRAIN_CYCLES  = 60;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_LIMIT  = 10;

	typedef struct {
		logic               opcode;
		logic signed [23:0] ti;
		logic signed [23:0] te;
		logic signed [23:0] u;
	} cell_t;

	typedef struct {
		logic [23:0] factor;
		logic [31:0] energy;
		logic        sat;
	} energy_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [23:0]        cfg_factor = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               opcode = 1'b0;
	logic signed [23:0] ion_temp = '0;
	logic signed [23:0] electron_temp = '0;
	logic signed [23:0] flow_speed = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [23:0]        sheath_factor;
	logic [31:0]        incident_energy;
	logic               saturated;

	cell_t   cell_queue[$];
	energy_t energy_expect[$];
	logic [23:0] factor_reg = '0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	cell_t loaded;
	cell_t taken;
	energy_t want;
	logic [23:0] factor_plan [8];

	sheath_incident_energy u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.fixed_sheath_factor (cfg_factor),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.opcode              (opcode),
		.ion_temp            (ion_temp),
		.electron_temp       (electron_temp),
		.flow_speed          (flow_speed),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.sheath_factor       (sheath_factor),
		.incident_energy     (incident_energy),
		.saturated           (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// log2 of a positive value with 24 fraction bits, taken by repeated
	// squaring of the normalized mantissa.
	function automatic longint log2_fix(input int unsigned x);
		int msb;
		longint unsigned m;
		longint frac;
		msb = 0;
		frac = 0;
		for (int i = 0; i < 32; i++)
			if (x[i])
				msb = i;
		m = longint'(x) << (31 - msb);
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return longint'(msb) * 64'd16777216 + frac;
	endfunction

	function automatic logic [23:0] factor_of(input logic [23:0] fixed_val,
			input logic signed [23:0] te, input logic signed [23:0] u);
		longint s;
		longint unsigned prod;
		int unsigned mag;
		if (fixed_val != 0)
			return fixed_val;
		if (te <= 0 || u == 0)
			return FACTOR_FALLBACK;
		mag = 32'((u < 0) ? -longint'(u) : longint'(u));
		s = log2_fix(32'(te)) - 2 * log2_fix(mag) + longint'(LOG_OFFSET);
		if (s <= 0)
			return '0;
		prod = longint'(s) * longint'(HALF_LN2) + (64'd1 << 39);
		prod = prod >> 40;
		if (prod > 64'hFFFFFF)
			return 24'hFFFFFF;
		return prod[23:0];
	endfunction

	function automatic energy_t predict_incident(input cell_t c, input logic [23:0] fixed_val);
		energy_t r;
		longint sum;
		longint unsigned e;
		r.factor = factor_of(fixed_val, c.te, c.u);
		if (c.opcode == OP_TARGET)
			sum = longint'(c.ti) * 3 * 65536 + longint'(c.te) * 32768;
		else
			sum = longint'(c.ti) * 2 * 65536;
		sum = sum + longint'(r.factor) * longint'(c.te);
		e = 0;
		r.sat = 1'b0;
		// The sum is in Q.24; round half up to Q.8, clamp at zero.
		if (sum > 0) begin
			e = (longint'(sum) + 32768) >> 16;
			if (e > 64'hFFFF_FFFF) begin
				e = 64'hFFFF_FFFF;
				r.sat = 1'b1;
			end
		end
		r.energy = e[31:0];
		return r;
	endfunction

	// Random magnitude of random bit length, so that small and large values
	// are equally likely.
	function automatic logic signed [23:0] span_value(input int max_w, input bit neg_ok);
		int unsigned w;
		logic [31:0] v;
		w = $urandom_range(max_w, 1);
		v = $urandom & ((32'h1 << w) - 1);
		if (neg_ok && $urandom_range(1) == 1)
			v = -v;
		return v[23:0];
	endfunction

	function automatic cell_t random_cell();
		cell_t c;
		int unsigned pick;
		logic [31:0] r;
		pick = $urandom_range(99);
		c.opcode = 1'($urandom_range(1));
		c.ti = span_value(24, 1);
		if (pick < 75) begin
			// Positive Te and moving ions: the computed factor path.
			c.te = span_value(23, 0);
			if (c.te == 0)
				c.te = 1;
			c.u = span_value(24, 1);
			if (c.u == 0)
				c.u = T_MIN;
		end else if (pick < 85) begin
			c.te = -span_value(23, 0);
			c.u = span_value(24, 1);
		end else if (pick < 92) begin
			c.te = span_value(24, 1);
			c.u = '0;
		end else begin
			r = $urandom;
			c.ti = r[23:0];
			r = $urandom;
			c.te = r[23:0];
			r = $urandom;
			c.u = r[23:0];
		end
		return c;
	endfunction

	task automatic push_cell(input logic op, input logic signed [23:0] ti,
			input logic signed [23:0] te, input logic signed [23:0] u);
		cell_t c;
		c.opcode = op;
		c.ti = ti;
		c.te = te;
		c.u = u;
		cell_queue.push_back(c);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (cell_queue.size() != 0 || in_valid || energy_expect.size() != 0);
	endtask

	task automatic write_factor(input logic [23:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_factor <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		factor_reg = value;
		@(negedge clk);
	endtask

	// Driver: a transaction stays on the port until it is accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				taken.opcode = opcode;
				taken.ti = ion_temp;
				taken.te = electron_temp;
				taken.u = flow_speed;
				energy_expect.push_back(predict_incident(taken, factor_reg));
			end
			if (!in_valid || !in_stall) begin
				if (cell_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					loaded = cell_queue.pop_front();
					in_valid <= 1'b1;
					opcode <= loaded.opcode;
					ion_temp <= loaded.ti;
					electron_temp <= loaded.te;
					flow_speed <= loaded.u;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (energy_expect.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result: factor %h energy %h sat %b",
						sheath_factor, incident_energy, saturated);
			end else begin
				want = energy_expect.pop_front();
				if (sheath_factor !== want.factor || incident_energy !== want.energy ||
						saturated !== want.sat) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("mismatch: exp %h %h %b, got %h %h %b",
							want.factor, want.energy, want.sat,
							sheath_factor, incident_energy, saturated);
				end
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed cells with the register at its reset value.
		push_cell(OP_TARGET, 0, 0, 0);
		push_cell(OP_RADIAL, 0, 0, 0);
		push_cell(OP_TARGET, T_MAX, T_MAX, 1);
		push_cell(OP_RADIAL, T_MAX, T_MAX, 1);
		push_cell(OP_TARGET, T_MIN, T_MIN, T_MIN);
		push_cell(OP_RADIAL, T_MIN, 100, 5);
		push_cell(OP_TARGET, 256, 256, 0);
		push_cell(OP_TARGET, 256, -256, 1000);
		push_cell(OP_TARGET, 256, 1, T_MAX);
		push_cell(OP_TARGET, 256, 1, T_MIN);
		push_cell(OP_TARGET, 256, 2560, 10000);
		push_cell(OP_RADIAL, 256, 2560, -10000);
		push_cell(OP_TARGET, 256, 2560, -1);
		push_cell(OP_TARGET, 1, 1, 1);
		push_cell(OP_TARGET, -1, -1, -1);
		push_cell(OP_RADIAL, -1, 1, 1);
		// Speeds around where the computed factor crosses zero.
		push_cell(OP_TARGET, 2560, 2560, 400000);
		push_cell(OP_TARGET, 2560, 2560, -600000);
		push_cell(OP_TARGET, 0, T_MAX, T_MAX);
		push_cell(OP_RADIAL, T_MAX, T_MIN, 0);
		push_cell(OP_TARGET, T_MIN, T_MAX, 1);
		push_cell(OP_RADIAL, T_MIN, T_MAX, T_MIN);

		factor_plan[0] = 24'h000000;
		factor_plan[1] = 24'h000000;
		factor_plan[2] = 24'hFFFFFF;
		factor_plan[3] = 24'h000000;
		factor_plan[4] = 24'h000001;
		factor_plan[5] = 24'h000000;
		factor_plan[6] = 24'($urandom_range(24'hFFFFFF, 1));
		factor_plan[7] = 24'h000000;

		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			write_factor(factor_plan[ph]);
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = IDLE_HEAVY;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = IDLE_HEAVY;
				end
				default: begin
					send_idle_pct = IDLE_LIGHT;
					stall_pct = IDLE_LIGHT;
				end
			endcase
			repeat (PHASE_CELLS) cell_queue.push_back(random_cell());
		end

		wait_drained();
		send_idle_pct = 0;
		stall_pct = 0;
		// Any result arriving now has no prediction and counts as a failure.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
